### hdl/bbq_pkg.sv
// ----------------------------------------------------------------------------
// bbq_pkg
// Shared types, widths and codes of the byte budget drop oldest record queue.
// ----------------------------------------------------------------------------
package bbq_pkg;

  // field widths
  localparam int TYPE_W     = 2;
  localparam int TAG_IN_W   = 32;
  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 24;
  localparam int CTR_W      = 64;
  localparam int CFG_IDX_W  = 2;

  // descriptor ring geometry
  localparam int RING_DEPTH = 16;
  localparam int TAG_BITS   = 32;
  localparam int TAG_W      = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // most records one drain may return
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // register reset values
  localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST = BYTE_W'(65536);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTING        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFIER_PRESENT = CFG_IDX_W'(2);

  // request codes
  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH          = 2'd0,
    REQ_DRAIN         = 2'd1,
    REQ_TAKE_DROPPED  = 2'd2,
    REQ_TAKE_RECEIVED = 2'd3
  } req_type_t;

  // result codes
  typedef enum logic [TYPE_W-1:0] {
    RESP_ACK     = 2'd0,
    RESP_RECORD  = 2'd1,
    RESP_EMPTY   = 2'd2,
    RESP_COUNTER = 2'd3
  } resp_kind_t;

  // ring control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  // ring status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

  // operands of the shared add/compare unit
  typedef struct packed {
    logic [CTR_W-1:0]  a;
    logic [CTR_W-1:0]  b;
    logic              sub;
    logic [BYTE_W-1:0] lim;
  } alu_req_t;

endpackage

### hdl/bbq_alu.sv
// ----------------------------------------------------------------------------
// bbq_alu
// Shared 64-bit add/subtract unit with a compare of the sum against a limit.
// ----------------------------------------------------------------------------
module bbq_alu (
  input  bbq_pkg::alu_req_t          req,
  output logic [bbq_pkg::CTR_W-1:0]  sum,
  output logic                       gt
);

  logic [bbq_pkg::CTR_W-1:0] b_eff;

  // two's complement operand for subtract
  assign b_eff = req.sub ? ~req.b : req.b;
  assign sum   = req.a + b_eff + bbq_pkg::CTR_W'(req.sub);

  // sum above the limit
  assign gt = (sum[bbq_pkg::CTR_W-1:bbq_pkg::BYTE_W] != '0) ||
              (sum[bbq_pkg::BYTE_W-1:0] > req.lim);

endmodule

### hdl/bbq_ring.sv
// ----------------------------------------------------------------------------
// bbq_ring
// Descriptor ring of record tags and lengths with head, tail and fill count.
// ----------------------------------------------------------------------------
module bbq_ring (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bbq_pkg::ring_ctl_t          ctl,
  input  logic [bbq_pkg::TAG_W-1:0]   wr_tag,
  input  logic [bbq_pkg::LEN_W-1:0]   wr_len,
  output logic [bbq_pkg::TAG_W-1:0]   head_tag,
  output logic [bbq_pkg::LEN_W-1:0]   head_len,
  output bbq_pkg::ring_stat_t         stat
);

  logic [bbq_pkg::TAG_W-1:0] tag_mem [bbq_pkg::RING_DEPTH];
  logic [bbq_pkg::LEN_W-1:0] len_mem [bbq_pkg::RING_DEPTH];
  logic [bbq_pkg::IDX_W-1:0] head_r;
  logic [bbq_pkg::IDX_W-1:0] tail_r;
  logic [bbq_pkg::CNT_W-1:0] count_r;
  logic [bbq_pkg::IDX_W-1:0] head_nxt;
  logic [bbq_pkg::IDX_W-1:0] tail_nxt;

  // index advance with wrap
  assign head_nxt = (head_r == bbq_pkg::IDX_W'(bbq_pkg::RING_DEPTH - 1)) ?
                    '0 : head_r + 1'b1;
  assign tail_nxt = (tail_r == bbq_pkg::IDX_W'(bbq_pkg::RING_DEPTH - 1)) ?
                    '0 : tail_r + 1'b1;

  // head entry and fill status
  assign head_tag   = tag_mem[head_r];
  assign head_len   = len_mem[head_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == bbq_pkg::CNT_W'(bbq_pkg::RING_DEPTH));

  // entry storage
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      tag_mem[tail_r] <= wr_tag;
      len_mem[tail_r] <= wr_len;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (ctl.push) begin
        tail_r  <= tail_nxt;
        count_r <= count_r + 1'b1;
      end else if (ctl.pop) begin
        head_r  <= head_nxt;
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hdl/byte_budget_drop_oldest_queue.sv
// ----------------------------------------------------------------------------
// byte_budget_drop_oldest_queue
// Record descriptor queue held under a byte limit; drops oldest on overflow.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; results come back
// on the out_ ports, each valid for one cycle under out_valid, and cannot be
// held off. Take requests, ignored pushes and zero budget drains answer at
// the next clock edge and never raise busy.
// A push steps through receive and check, then a drop and a pop for each record
// evicted, and ends in enqueue or refuse; a drain alternates check and pop,
// sends each record at the next pop and the last one with the final check.
// This stepping comes from the sequencer taking every add, subtract and
// compare through one shared 64-bit adder.
// ----------------------------------------------------------------------------
module byte_budget_drop_oldest_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic [bbq_pkg::TYPE_W-1:0]    in_req_type,
  input  logic [bbq_pkg::TAG_IN_W-1:0]  in_record_tag,
  input  logic [bbq_pkg::LEN_W-1:0]     in_record_length,
  input  logic [bbq_pkg::BYTE_W-1:0]    in_drain_budget,
  // configuration
  input  logic                          cfg_we,
  input  logic [bbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbq_pkg::BYTE_W-1:0]    cfg_data,
  // results
  output logic                          out_valid,
  output logic [bbq_pkg::TYPE_W-1:0]    out_resp_kind,
  output logic [bbq_pkg::TAG_IN_W-1:0]  out_tag,
  output logic [bbq_pkg::LEN_W-1:0]     out_length,
  output logic                          out_last,
  output logic [bbq_pkg::BYTE_W-1:0]    out_drained_total,
  output logic [bbq_pkg::CTR_W-1:0]     out_counter_value,
  output logic                          out_accepted,
  output logic                          out_notify_request,
  output logic [bbq_pkg::BYTE_W-1:0]    out_queued_bytes_now,
  output logic                          out_pending_now
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RECV,
    S_P_CHECK,
    S_P_DROP,
    S_P_POP,
    S_P_REFUSE,
    S_P_ENQ,
    S_D_CHECK,
    S_D_POP
  } state_t;

  typedef struct packed {
    bbq_pkg::resp_kind_t          kind;
    logic [bbq_pkg::TAG_W-1:0]    tag;
    logic [bbq_pkg::LEN_W-1:0]    len;
    logic                         last;
    logic [bbq_pkg::BYTE_W-1:0]   drained;
    logic [bbq_pkg::CTR_W-1:0]    counter;
    logic                         acc;
    logic                         notify;
    logic [bbq_pkg::BYTE_W-1:0]   queued;
    logic                         pending;
  } res_t;

  function automatic res_t mk_res(
    input bbq_pkg::resp_kind_t        kind,
    input logic [bbq_pkg::TAG_W-1:0]  tag,
    input logic [bbq_pkg::LEN_W-1:0]  len,
    input logic                       last,
    input logic [bbq_pkg::BYTE_W-1:0] drained,
    input logic [bbq_pkg::CTR_W-1:0]  counter,
    input logic                       acc,
    input logic                       notify,
    input logic [bbq_pkg::BYTE_W-1:0] queued,
    input logic                       pending
  );
    res_t r;
    r.kind    = kind;
    r.tag     = tag;
    r.len     = len;
    r.last    = last;
    r.drained = drained;
    r.counter = counter;
    r.acc     = acc;
    r.notify  = notify;
    r.queued  = queued;
    r.pending = pending;
    return r;
  endfunction

  state_t                         state_r;
  logic [bbq_pkg::LEN_W-1:0]      len_r;
  logic [bbq_pkg::TAG_W-1:0]      tag_r;
  logic [bbq_pkg::BYTE_W-1:0]     budget_r;
  logic [bbq_pkg::BYTE_W-1:0]     queued_r;
  logic [bbq_pkg::CTR_W-1:0]      dropped_r;
  logic [bbq_pkg::CTR_W-1:0]      received_r;
  logic                           pending_r;
  logic [bbq_pkg::BYTE_W-1:0]     limit_r;
  logic                           accepting_r;
  logic                           notifier_r;
  logic [bbq_pkg::BYTE_W-1:0]     drained_r;
  logic [bbq_pkg::RES_CNT_W-1:0]  rec_cnt_r;
  logic                           held_valid_r;
  logic [bbq_pkg::TAG_W-1:0]      held_tag_r;
  logic [bbq_pkg::LEN_W-1:0]      held_len_r;
  logic [bbq_pkg::BYTE_W-1:0]     held_drained_r;
  logic [bbq_pkg::BYTE_W-1:0]     held_queued_r;
  logic                           out_valid_r;
  res_t                           out_r;

  bbq_pkg::alu_req_t              alu_req;
  logic [bbq_pkg::CTR_W-1:0]      alu_sum;
  logic                           alu_gt;
  bbq_pkg::ring_ctl_t             ring_ctl;
  bbq_pkg::ring_stat_t            ring_stat;
  logic [bbq_pkg::TAG_W-1:0]      head_tag;
  logic [bbq_pkg::LEN_W-1:0]      head_len;
  logic                           d_stop;
  logic                           fin_pending;
  logic                           fin_notify;
  res_t                           fin_res;

  // shared add/compare unit
  bbq_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .gt  (alu_gt)
  );

  // descriptor ring
  bbq_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ring_ctl),
    .wr_tag   (tag_r),
    .wr_len   (len_r),
    .head_tag (head_tag),
    .head_len (head_len),
    .stat     (ring_stat)
  );

  // operand select per sequencer step
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_RECV: begin
        alu_req.a = received_r;
        alu_req.b = bbq_pkg::CTR_W'(len_r);
      end
      S_P_CHECK, S_P_ENQ: begin
        alu_req.a   = bbq_pkg::CTR_W'(queued_r);
        alu_req.b   = bbq_pkg::CTR_W'(len_r);
        alu_req.lim = limit_r;
      end
      S_P_DROP: begin
        alu_req.a = dropped_r;
        alu_req.b = bbq_pkg::CTR_W'(head_len);
      end
      S_P_POP, S_D_POP: begin
        alu_req.a   = bbq_pkg::CTR_W'(queued_r);
        alu_req.b   = bbq_pkg::CTR_W'(head_len);
        alu_req.sub = 1'b1;
      end
      S_P_REFUSE: begin
        alu_req.a = dropped_r;
        alu_req.b = bbq_pkg::CTR_W'(len_r);
      end
      S_D_CHECK: begin
        alu_req.a   = bbq_pkg::CTR_W'(drained_r);
        alu_req.b   = bbq_pkg::CTR_W'(head_len);
        alu_req.lim = budget_r;
      end
      default: alu_req = '0;
    endcase
  end

  // ring moves
  always_comb begin
    ring_ctl.push = (state_r == S_P_ENQ);
    ring_ctl.pop  = (state_r == S_P_POP) || (state_r == S_D_POP);
  end

  // drain end and its final result
  always_comb begin
    d_stop = ring_stat.empty ||
             (rec_cnt_r == bbq_pkg::RES_CNT_W'(bbq_pkg::MAX_RESULTS)) ||
             ((drained_r != '0) && alu_gt);
    fin_pending = ring_stat.empty ? 1'b0 : pending_r;
    fin_notify  = !ring_stat.empty && pending_r && accepting_r && notifier_r;
    if (held_valid_r) begin
      fin_res = mk_res(bbq_pkg::RESP_RECORD, held_tag_r, held_len_r, 1'b1,
                       held_drained_r, '0, 1'b0, fin_notify, queued_r,
                       fin_pending);
    end else begin
      fin_res = mk_res(bbq_pkg::RESP_EMPTY, '0, '0, 1'b1, '0, '0, 1'b0,
                       fin_notify, queued_r, fin_pending);
    end
  end

  // sequencer, state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      queued_r     <= '0;
      dropped_r    <= '0;
      received_r   <= '0;
      pending_r    <= 1'b0;
      limit_r      <= bbq_pkg::BYTE_LIMIT_RST;
      accepting_r  <= 1'b1;
      notifier_r   <= 1'b1;
      drained_r    <= '0;
      rec_cnt_r    <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          bbq_pkg::CFG_BYTE_LIMIT: limit_r <= cfg_data;
          bbq_pkg::CFG_ACCEPTING: begin
            accepting_r <= cfg_data[0];
            if (!cfg_data[0]) begin
              pending_r <= 1'b0;
            end
          end
          bbq_pkg::CFG_NOTIFIER_PRESENT: notifier_r <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            len_r        <= in_record_length;
            tag_r        <= in_record_tag[bbq_pkg::TAG_W-1:0];
            budget_r     <= in_drain_budget;
            drained_r    <= '0;
            rec_cnt_r    <= '0;
            held_valid_r <= 1'b0;
            unique case (bbq_pkg::req_type_t'(in_req_type))
              bbq_pkg::REQ_PUSH: begin
                if (in_record_length == '0 || !accepting_r) begin
                  out_valid_r <= 1'b1;
                  out_r <= mk_res(bbq_pkg::RESP_ACK, '0, '0, 1'b1, '0, '0,
                                  1'b0, 1'b0, queued_r, pending_r);
                end else begin
                  state_r <= S_RECV;
                end
              end
              bbq_pkg::REQ_DRAIN: begin
                if (in_drain_budget == '0) begin
                  out_valid_r <= 1'b1;
                  out_r <= mk_res(bbq_pkg::RESP_EMPTY, '0, '0, 1'b1, '0, '0,
                                  1'b0, 1'b0, queued_r, pending_r);
                end else begin
                  state_r <= S_D_CHECK;
                end
              end
              bbq_pkg::REQ_TAKE_DROPPED: begin
                out_valid_r <= 1'b1;
                out_r <= mk_res(bbq_pkg::RESP_COUNTER, '0, '0, 1'b1, '0,
                                dropped_r, 1'b0, 1'b0, queued_r, pending_r);
                dropped_r <= '0;
              end
              bbq_pkg::REQ_TAKE_RECEIVED: begin
                out_valid_r <= 1'b1;
                out_r <= mk_res(bbq_pkg::RESP_COUNTER, '0, '0, 1'b1, '0,
                                received_r, 1'b0, 1'b0, queued_r, pending_r);
                received_r <= '0;
              end
            endcase
          end
        end

        // count the pushed bytes as received
        S_RECV: begin
          received_r <= alu_sum;
          state_r    <= S_P_CHECK;
        end

        // evict, refuse or enqueue
        S_P_CHECK: begin
          priority if (alu_gt && !ring_stat.empty) begin
            state_r <= S_P_DROP;
          end else if (alu_gt) begin
            state_r <= S_P_REFUSE;
          end else if (ring_stat.full) begin
            state_r <= S_P_DROP;
          end else begin
            state_r <= S_P_ENQ;
          end
        end

        // oldest record goes to the dropped count
        S_P_DROP: begin
          dropped_r <= alu_sum;
          state_r   <= S_P_POP;
        end

        S_P_POP: begin
          queued_r <= alu_sum[bbq_pkg::BYTE_W-1:0];
          state_r  <= S_P_CHECK;
        end

        // record larger than the limit
        S_P_REFUSE: begin
          dropped_r   <= alu_sum;
          out_valid_r <= 1'b1;
          out_r <= mk_res(bbq_pkg::RESP_ACK, '0, '0, 1'b1, '0, '0, 1'b0, 1'b0,
                          queued_r, pending_r);
          state_r <= S_IDLE;
        end

        S_P_ENQ: begin
          queued_r    <= alu_sum[bbq_pkg::BYTE_W-1:0];
          pending_r   <= 1'b1;
          out_valid_r <= 1'b1;
          out_r <= mk_res(bbq_pkg::RESP_ACK, '0, '0, 1'b1, '0, '0, 1'b1,
                          !pending_r && notifier_r,
                          alu_sum[bbq_pkg::BYTE_W-1:0], 1'b1);
          state_r <= S_IDLE;
        end

        // next record fits the budget or the drain ends
        S_D_CHECK: begin
          if (d_stop) begin
            pending_r   <= fin_pending;
            out_valid_r <= 1'b1;
            out_r       <= fin_res;
            state_r     <= S_IDLE;
          end else begin
            drained_r <= alu_sum[bbq_pkg::BYTE_W-1:0];
            state_r   <= S_D_POP;
          end
        end

        // pop head, release the record held from the previous step
        S_D_POP: begin
          queued_r <= alu_sum[bbq_pkg::BYTE_W-1:0];
          if (held_valid_r) begin
            out_valid_r <= 1'b1;
            out_r <= mk_res(bbq_pkg::RESP_RECORD, held_tag_r, held_len_r, 1'b0,
                            held_drained_r, '0, 1'b0, 1'b0, held_queued_r,
                            pending_r);
          end
          held_valid_r   <= 1'b1;
          held_tag_r     <= head_tag;
          held_len_r     <= head_len;
          held_drained_r <= drained_r;
          held_queued_r  <= alu_sum[bbq_pkg::BYTE_W-1:0];
          rec_cnt_r      <= rec_cnt_r + 1'b1;
          state_r        <= S_D_CHECK;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ports
  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_resp_kind        = out_r.kind;
  assign out_tag              = bbq_pkg::TAG_IN_W'(out_r.tag);
  assign out_length           = out_r.len;
  assign out_last             = out_r.last;
  assign out_drained_total    = out_r.drained;
  assign out_counter_value    = out_r.counter;
  assign out_accepted         = out_r.acc;
  assign out_notify_request   = out_r.notify;
  assign out_queued_bytes_now = out_r.queued;
  assign out_pending_now      = out_r.pending;

endmodule

### bench/bbq_record_queue_checker.sv
// ----------------------------------------------------------------------------
// bbq_record_queue_checker
// Watches the request, configuration and result ports of the record queue,
// keeps its own copy of the ring, byte totals and pending flag, works out the
// responses of every accepted request and compares each response field by
// field with the oldest one still owed.
// ----------------------------------------------------------------------------
module bbq_record_queue_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  // request
  input  logic                          start,
  input  logic                          busy,
  input  logic [bbq_pkg::TYPE_W-1:0]    in_req_type,
  input  logic [bbq_pkg::TAG_IN_W-1:0]  in_record_tag,
  input  logic [bbq_pkg::LEN_W-1:0]     in_record_length,
  input  logic [bbq_pkg::BYTE_W-1:0]    in_drain_budget,
  // configuration
  input  logic                          cfg_we,
  input  logic [bbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbq_pkg::BYTE_W-1:0]    cfg_data,
  // results
  input  logic                          out_valid,
  input  logic [bbq_pkg::TYPE_W-1:0]    out_resp_kind,
  input  logic [bbq_pkg::TAG_IN_W-1:0]  out_tag,
  input  logic [bbq_pkg::LEN_W-1:0]     out_length,
  input  logic                          out_last,
  input  logic [bbq_pkg::BYTE_W-1:0]    out_drained_total,
  input  logic [bbq_pkg::CTR_W-1:0]     out_counter_value,
  input  logic                          out_accepted,
  input  logic                          out_notify_request,
  input  logic [bbq_pkg::BYTE_W-1:0]    out_queued_bytes_now,
  input  logic                          out_pending_now,
  // status to the testbench top
  output int                            error_count,
  output int                            responses_owed
);
  import bbq_pkg::*;

  typedef struct packed {
    resp_kind_t          kind;
    logic [TAG_IN_W-1:0] tag;
    logic [LEN_W-1:0]    length;
    logic                last;
    logic [BYTE_W-1:0]   drained;
    logic [CTR_W-1:0]    counter;
    logic                accepted;
    logic                notify;
    logic [BYTE_W-1:0]   queued;
    logic                pending;
  } response_t;

  // shadow ring, byte totals and flags
  logic [TAG_W-1:0]  ring_tag [RING_DEPTH];
  logic [LEN_W-1:0]  ring_len [RING_DEPTH];
  int                head;
  int                tail;
  int                entries;
  logic [BYTE_W-1:0] queued_bytes;
  logic [CTR_W-1:0]  dropped_bytes;
  logic [CTR_W-1:0]  received_bytes;
  logic              notice_pending;

  // shadow registers
  logic [BYTE_W-1:0] byte_limit;
  logic              accepting;
  logic              notifier;

  // responses owed, oldest first
  response_t due_responses[$];

  function automatic response_t make_response(resp_kind_t kind, logic [TAG_IN_W-1:0] tag,
                                              logic [LEN_W-1:0] len, logic last,
                                              logic [BYTE_W-1:0] drained,
                                              logic [CTR_W-1:0] counter,
                                              logic acc, logic notify);
    response_t r;
    r.kind     = kind;
    r.tag      = tag;
    r.length   = len;
    r.last     = last;
    r.drained  = drained;
    r.counter  = counter;
    r.accepted = acc;
    r.notify   = notify;
    r.queued   = queued_bytes;
    r.pending  = notice_pending;
    return r;
  endfunction

  // append one response to the owed list
  task automatic owe(response_t r);
    due_responses = {due_responses, r};
  endtask

  task automatic reset_queue_state();
    head           = 0;
    tail           = 0;
    entries        = 0;
    queued_bytes   = '0;
    dropped_bytes  = '0;
    received_bytes = '0;
    notice_pending = 1'b0;
    byte_limit     = BYTE_LIMIT_RST;
    accepting      = 1'b1;
    notifier       = 1'b1;
    due_responses.delete();
  endtask

  task automatic apply_register_write(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    case (idx)
      CFG_BYTE_LIMIT: byte_limit = data;
      CFG_ACCEPTING: begin
        accepting = data[0];
        if (!data[0]) notice_pending = 1'b0;
      end
      CFG_NOTIFIER_PRESENT: notifier = data[0];
      default: ;
    endcase
  endtask

  // remove the oldest record without counting it as dropped
  task automatic pop_oldest();
    queued_bytes = queued_bytes - BYTE_W'(ring_len[head]);
    head         = (head + 1) % RING_DEPTH;
    entries--;
  endtask

  task automatic evict_oldest();
    dropped_bytes = dropped_bytes + CTR_W'(ring_len[head]);
    pop_oldest();
  endtask

  // one accepted request: update the shadow state and queue its responses
  task automatic step_record_queue(req_type_t kind, logic [TAG_IN_W-1:0] tag,
                                   logic [LEN_W-1:0] len, logic [BYTE_W-1:0] budget);
    response_t   batch[$];
    response_t   fin;
    logic [31:0] drained;
    logic [31:0] fill;
    logic        notify;
    logic [TAG_W-1:0] rec_tag;
    logic [LEN_W-1:0] rec_len;
    case (kind)
      REQ_PUSH: begin
        if (len == '0 || !accepting) begin
          owe(make_response(RESP_ACK, '0, '0, 1'b1, '0, '0, 1'b0, 1'b0));
        end else begin
          received_bytes = received_bytes + CTR_W'(len);
          // make room by evicting from the front
          fill = 32'(queued_bytes) + 32'(len);
          while (entries > 0 && fill > 32'(byte_limit)) begin
            evict_oldest();
            fill = 32'(queued_bytes) + 32'(len);
          end
          if (32'(len) > 32'(byte_limit)) begin
            // record can never fit, refuse it
            dropped_bytes = dropped_bytes + CTR_W'(len);
            owe(make_response(RESP_ACK, '0, '0, 1'b1, '0, '0, 1'b0, 1'b0));
          end else begin
            if (entries >= RING_DEPTH) evict_oldest();
            ring_tag[tail] = tag[TAG_W-1:0];
            ring_len[tail] = len;
            tail           = (tail + 1) % RING_DEPTH;
            entries++;
            queued_bytes   = queued_bytes + BYTE_W'(len);
            notify         = 1'b0;
            if (!notice_pending) begin
              notice_pending = 1'b1;
              notify         = notifier;
            end
            owe(make_response(RESP_ACK, '0, '0, 1'b1, '0, '0, 1'b1, notify));
          end
        end
      end
      REQ_DRAIN: begin
        if (budget == '0) begin
          owe(make_response(RESP_EMPTY, '0, '0, 1'b1, '0, '0, 1'b0, 1'b0));
        end else begin
          drained = '0;
          // at least one record when any is queued, then only while the budget holds
          while (entries > 0 && batch.size() < MAX_RESULTS &&
                 (drained == '0 || drained + 32'(ring_len[head]) <= 32'(budget))) begin
            rec_tag = ring_tag[head];
            rec_len = ring_len[head];
            drained = drained + 32'(rec_len);
            pop_oldest();
            batch = {batch, make_response(RESP_RECORD, TAG_IN_W'(rec_tag), rec_len, 1'b0,
                                          drained[BYTE_W-1:0], '0, 1'b0, 1'b0)};
          end
          if (entries == 0) begin
            notice_pending = 1'b0;
            notify         = 1'b0;
          end else begin
            notify = notice_pending && accepting && notifier;
          end
          if (batch.size() == 0) begin
            owe(make_response(RESP_EMPTY, '0, '0, 1'b1, '0, '0, 1'b0, notify));
          end else begin
            // final record carries the closing status
            fin         = batch.pop_back();
            fin.last    = 1'b1;
            fin.notify  = notify;
            fin.queued  = queued_bytes;
            fin.pending = notice_pending;
            batch       = {batch, fin};
            foreach (batch[i]) owe(batch[i]);
          end
        end
      end
      REQ_TAKE_DROPPED: begin
        owe(make_response(RESP_COUNTER, '0, '0, 1'b1, '0, dropped_bytes, 1'b0, 1'b0));
        dropped_bytes = '0;
      end
      default: begin
        owe(make_response(RESP_COUNTER, '0, '0, 1'b1, '0, received_bytes, 1'b0, 1'b0));
        received_bytes = '0;
      end
    endcase
  endtask

  task automatic check_field(string name, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // results first, then register writes, then the new request
  always @(posedge clk) begin : watch
    response_t want;
    if (!rst_n) begin
      reset_queue_state();
    end else begin
      if (out_valid) begin
        if (due_responses.size() == 0) begin
          $error("response with nothing owed: kind %0d", out_resp_kind);
          error_count++;
        end else begin
          want = due_responses[0];
          due_responses.delete(0);
          check_field("resp_kind", CTR_W'(want.kind), CTR_W'(out_resp_kind));
          check_field("tag", CTR_W'(want.tag), CTR_W'(out_tag));
          check_field("length", CTR_W'(want.length), CTR_W'(out_length));
          check_field("last", CTR_W'(want.last), CTR_W'(out_last));
          check_field("drained_total", CTR_W'(want.drained), CTR_W'(out_drained_total));
          check_field("counter_value", want.counter, out_counter_value);
          check_field("accepted", CTR_W'(want.accepted), CTR_W'(out_accepted));
          check_field("notify_request", CTR_W'(want.notify), CTR_W'(out_notify_request));
          check_field("queued_bytes_now", CTR_W'(want.queued), CTR_W'(out_queued_bytes_now));
          check_field("pending_now", CTR_W'(want.pending), CTR_W'(out_pending_now));
        end
      end
      if (cfg_we) apply_register_write(cfg_index, cfg_data);
      if (start && !busy) begin
        step_record_queue(req_type_t'(in_req_type), in_record_tag, in_record_length,
                          in_drain_budget);
      end
    end
    responses_owed <= due_responses.size();
  end

endmodule

### bench/tb_byte_budget_drop_oldest_queue.sv
// ----------------------------------------------------------------------------
// tb_byte_budget_drop_oldest_queue
// Drives the record queue with a directed opening (reset counters, empty and
// zero budget drains, largest records, eviction, oversized records, refused
// pushes) and then random phases under different byte limits and flag
// settings, with push bursts that fill the ring. A side checker predicts and
// compares every response; this module makes requests and gives the verdict.
// ----------------------------------------------------------------------------
module tb_byte_budget_drop_oldest_queue;
  import bbq_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [TYPE_W-1:0]    in_req_type;
  logic [TAG_IN_W-1:0]  in_record_tag;
  logic [LEN_W-1:0]     in_record_length;
  logic [BYTE_W-1:0]    in_drain_budget;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 out_valid;
  logic [TYPE_W-1:0]    out_resp_kind;
  logic [TAG_IN_W-1:0]  out_tag;
  logic [LEN_W-1:0]     out_length;
  logic                 out_last;
  logic [BYTE_W-1:0]    out_drained_total;
  logic [CTR_W-1:0]     out_counter_value;
  logic                 out_accepted;
  logic                 out_notify_request;
  logic [BYTE_W-1:0]    out_queued_bytes_now;
  logic                 out_pending_now;

  int   error_count;
  int   responses_owed;
  int   quiet_cycles;
  int   len_cap;
  logic no_gaps;

  byte_budget_drop_oldest_queue dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_record_tag        (in_record_tag),
    .in_record_length     (in_record_length),
    .in_drain_budget      (in_drain_budget),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_resp_kind        (out_resp_kind),
    .out_tag              (out_tag),
    .out_length           (out_length),
    .out_last             (out_last),
    .out_drained_total    (out_drained_total),
    .out_counter_value    (out_counter_value),
    .out_accepted         (out_accepted),
    .out_notify_request   (out_notify_request),
    .out_queued_bytes_now (out_queued_bytes_now),
    .out_pending_now      (out_pending_now)
  );

  bbq_record_queue_checker u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_record_tag        (in_record_tag),
    .in_record_length     (in_record_length),
    .in_drain_budget      (in_drain_budget),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_resp_kind        (out_resp_kind),
    .out_tag              (out_tag),
    .out_length           (out_length),
    .out_last             (out_last),
    .out_drained_total    (out_drained_total),
    .out_counter_value    (out_counter_value),
    .out_accepted         (out_accepted),
    .out_notify_request   (out_notify_request),
    .out_queued_bytes_now (out_queued_bytes_now),
    .out_pending_now      (out_pending_now),
    .error_count          (error_count),
    .responses_owed       (responses_owed)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog on cycles with no request, result or register write
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // idle gap before a request: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 12) return LEN_W'($urandom);
    if (roll < 15) return '1;
    return LEN_W'($urandom_range(1, len_cap));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_budget();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 18) return BYTE_W'($urandom);
    if (roll < 22) return '1;
    return BYTE_W'($urandom_range(1, len_cap * 4));
  endfunction

  // present one request and hold it until accepted
  task automatic issue(req_type_t kind, logic [TAG_IN_W-1:0] tag, logic [LEN_W-1:0] len,
                       logic [BYTE_W-1:0] budget);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start            <= 1'b1;
    in_req_type      <= kind;
    in_record_tag    <= tag;
    in_record_length <= len;
    in_drain_budget  <= budget;
    // busy only moves at a rising edge, so it is steady here
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic random_request();
    int        roll;
    req_type_t kind;
    roll = $urandom_range(99);
    if (roll < 55) kind = REQ_PUSH;
    else if (roll < 85) kind = REQ_DRAIN;
    else if (roll < 93) kind = REQ_TAKE_DROPPED;
    else kind = REQ_TAKE_RECEIVED;
    issue(kind, $urandom, pick_length(), pick_budget());
  endtask

  // stop requesting and wait for every owed response and an idle block
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (responses_owed != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // flag writes carry random upper bits, only bit 0 counts
  task automatic set_config(logic [BYTE_W-1:0] limit, logic acc, logic notif);
    write_reg(CFG_BYTE_LIMIT, limit);
    write_reg(CFG_ACCEPTING, {(BYTE_W-1)'($urandom), acc});
    write_reg(CFG_NOTIFIER_PRESENT, {(BYTE_W-1)'($urandom), notif});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int          items;
    int          per_phase;
    int          burst;
    logic [BYTE_W-1:0] limit;
    logic        acc;
    start            = 1'b0;
    rst_n            = 1'b0;
    in_req_type      = REQ_PUSH;
    in_record_tag    = '0;
    in_record_length = '0;
    in_drain_budget  = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_BYTE_LIMIT;
    cfg_data         = '0;
    no_gaps          = 1'b0;
    len_cap          = 64;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: counters, empty drains, largest record, eviction
    issue(REQ_TAKE_DROPPED, '0, '0, '0);
    issue(REQ_TAKE_RECEIVED, '0, '0, '0);
    issue(REQ_DRAIN, '0, '0, 24'd5);
    issue(REQ_DRAIN, '0, '0, '0);
    issue(REQ_PUSH, 32'h1234_5678, '0, '0);
    issue(REQ_PUSH, '1, '1, '0);
    issue(REQ_PUSH, '0, 16'd1, '0);
    issue(REQ_PUSH, 32'hA5A5_A5A5, 16'd2, '0);
    issue(REQ_DRAIN, '0, '0, 24'd1);
    issue(REQ_DRAIN, '0, '0, '0);
    issue(REQ_DRAIN, '0, '0, '1);
    issue(REQ_TAKE_DROPPED, '0, '0, '0);
    issue(REQ_TAKE_RECEIVED, '0, '0, '0);

    // one byte limit, no notifier: oversized record empties the queue
    settle();
    set_config(24'd1, 1'b1, 1'b0);
    issue(REQ_PUSH, 32'h5A5A_5A5A, 16'd1, '0);
    issue(REQ_PUSH, 32'hFFFF_0000, 16'd2, '0);
    issue(REQ_PUSH, 32'h0000_FFFF, 16'd1, '0);

    // intake stopped: push refused, leftover record drained
    settle();
    set_config('1, 1'b0, 1'b1);
    issue(REQ_PUSH, 32'hDEAD_0001, 16'd5, '0);
    issue(REQ_DRAIN, '0, '0, '1);
    issue(REQ_TAKE_DROPPED, '0, '0, '0);
    issue(REQ_TAKE_RECEIVED, '0, '0, '0);

    // random phases under different limits and flags
    for (int phase = 0; phase < 7; phase++) begin
      per_phase = 50;
      acc       = 1'b1;
      no_gaps   = 1'b0;
      case (phase)
        0: begin
          limit   = '1;
          len_cap = 2000;
        end
        1: begin
          limit   = 24'd1;
          len_cap = 2;
        end
        2: begin
          limit     = '0;
          len_cap   = 16;
          per_phase = 30;
        end
        3: begin
          limit   = BYTE_W'($urandom);
          len_cap = 65535;
          no_gaps = 1'b1;
        end
        4: begin
          limit   = BYTE_W'($urandom_range(50, 500));
          len_cap = 120;
        end
        5: begin
          limit   = BYTE_W'($urandom_range(1000, 20000));
          len_cap = 3000;
        end
        default: begin
          limit   = BYTE_W'($urandom_range(100, 5000));
          len_cap = 400;
          acc     = 1'b0;
        end
      endcase
      settle();
      set_config(limit, acc, phase % 2 == 0);
      items = 0;
      while (items < per_phase) begin
        if ($urandom_range(99) < 8) begin
          // burst of pushes to fill the ring
          burst = $urandom_range(10, 20);
          repeat (burst) begin
            issue(REQ_PUSH, $urandom, LEN_W'($urandom_range(1, len_cap)), BYTE_W'($urandom));
          end
          items += burst;
        end else begin
          random_request();
          items++;
        end
      end
    end

    settle();
    repeat (40) @(negedge clk);
    if (error_count == 0 && responses_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
